[rtl/cfpv_pkg.sv]
`default_nettype none
package cfpv_pkg;

  localparam int MaxParamLen = 32;
  localparam int LenW = 6;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusShort = 2'd1;
  localparam logic [1:0] StatusTrunc = 2'd2;
  localparam logic [1:0] StatusInvalid = 2'd3;

  localparam logic [2:0] RegAngleLimit = 3'd0;
  localparam logic [2:0] RegAccelLimit = 3'd1;
  localparam logic [2:0] RegRateMin = 3'd2;
  localparam logic [2:0] RegRateMax = 3'd3;
  localparam logic [2:0] RegPeriodMin = 3'd4;
  localparam logic [2:0] RegPeriodMax = 3'd5;

  localparam logic [7:0] CmdAngle0 = 8'h10;
  localparam logic [7:0] CmdAngle1 = 8'h11;
  localparam logic [7:0] CmdAngle2 = 8'h12;
  localparam logic [7:0] CmdAccel = 8'h13;
  localparam logic [7:0] CmdMode = 8'h14;
  localparam logic [7:0] CmdRate = 8'h20;
  localparam logic [7:0] CmdPeriod = 8'h21;
  localparam logic [7:0] CmdPlain0 = 8'h30;
  localparam logic [7:0] CmdPlain1 = 8'h31;
  localparam logic [7:0] CmdPlain2 = 8'h32;
  localparam logic [7:0] CmdReset = 8'hFF;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       byte_present;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]      command_code;
    logic [LenW-1:0] param_length;
    logic            length_clamped;
    logic [31:0]     param_word;
    logic [1:0]      status;
  } out_item_t;

  typedef struct packed {
    logic [30:0] angle_limit_bits;
    logic [30:0] accel_limit_bits;
    logic [15:0] rate_min;
    logic [15:0] rate_max;
    logic [31:0] period_min;
    logic [31:0] period_max;
  } cfg_t;

endpackage
`default_nettype wire

[rtl/cfpv_check.sv]
`default_nettype none
module cfpv_check import cfpv_pkg::*; (
  input  wire cfg_t              cfg,
  input  wire logic [7:0]        code,
  input  wire logic [LenW-1:0]   len,
  input  wire logic [31:0]       word,
  output logic                   ok
);

  logic angle_ok;
  logic accel_ok;
  logic not_special;
  logic sign_ok;

  // exponent all ones means NaN or infinity; negative zero passes
  assign not_special = (word[30:23] != 8'hFF);
  assign sign_ok = !word[31] || (word[30:0] == 31'd0);
  assign angle_ok = not_special && sign_ok && (word[30:0] <= cfg.angle_limit_bits);
  assign accel_ok = not_special && sign_ok && (word[30:0] <= cfg.accel_limit_bits);

  always_comb begin
    case (code)
      CmdAngle0, CmdAngle1, CmdAngle2: ok = (len >= LenW'(4)) && angle_ok;
      CmdAccel: ok = (len >= LenW'(4)) && accel_ok;
      CmdMode: ok = (len >= LenW'(1));
      CmdRate: ok = (len >= LenW'(2)) && (word[15:0] >= cfg.rate_min)
                    && (word[15:0] <= cfg.rate_max);
      CmdPeriod: ok = (len >= LenW'(4)) && (word >= cfg.period_min)
                      && (word <= cfg.period_max);
      CmdPlain0, CmdPlain1, CmdPlain2, CmdReset: ok = 1'b1;
      default: ok = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/command_frame_parse_validate.sv]
// Command frame parser and validator.
// Input channel: one beat per frame byte (in_data.frame_byte with byte_present)
// and frame_end marking the last beat; a beat with frame_end and no byte ends
// the frame with what has arrived. Byte 0 is the code, byte 1 the declared
// length (clamped to 32), then parameters; the first four form param_word.
// Output channel: one result beat per frame end carrying code, length, clamp
// flag, param_word and status (ok, short, truncated, invalid).
// Throughput: one input beat per cycle. Latency: the result is registered,
// valid on the cycle after the frame_end beat is taken. The input side is
// stalled only while a result waits and a second frame end arrives; plain
// bytes keep flowing under output stall.
// Configuration: cfg_we/cfg_index/cfg_data write a limit register; write
// only while no frame is in progress.
// Reset (rst, synchronous): clears the frame state and the output valid and
// loads the default limits.
`default_nettype none
module command_frame_parse_validate import cfpv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire in_item_t    in_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  output out_item_t        out_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  cfg_t cfg;
  logic [7:0]  byte_count;
  logic [7:0]  code_reg;
  logic [7:0]  declared_len;
  logic [31:0] param_accum;

  logic [7:0]  byte_count_next;
  logic [7:0]  code_next;
  logic [7:0]  declared_next;
  logic [31:0] accum_next;
  logic [7:0]  clamp8;
  logic [LenW-1:0] len;
  logic        clamped;
  logic        ok;
  logic        take;
  out_item_t   result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_limit_bits <= 31'd1127481344;
      cfg.accel_limit_bits <= 31'd1098907648;
      cfg.rate_min <= 16'd1;
      cfg.rate_max <= 16'd1000;
      cfg.period_min <= 32'd10000;
      cfg.period_max <= 32'd10000000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegAngleLimit: cfg.angle_limit_bits <= cfg_data[30:0];
        RegAccelLimit: cfg.accel_limit_bits <= cfg_data[30:0];
        RegRateMin: cfg.rate_min <= cfg_data[15:0];
        RegRateMax: cfg.rate_max <= cfg_data[15:0];
        RegPeriodMin: cfg.period_min <= cfg_data;
        RegPeriodMax: cfg.period_max <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = out_valid && out_stall && in_data.frame_end;
  assign take = in_valid && !in_stall;

  // clamp from the currently stored declared length (byte 1 may arrive now)
  always_comb begin
    code_next = code_reg;
    declared_next = declared_len;
    accum_next = param_accum;
    byte_count_next = byte_count;
    if (in_data.byte_present) begin
      if (byte_count == 8'd0) begin
        code_next = in_data.frame_byte;
      end else if (byte_count == 8'd1) begin
        declared_next = in_data.frame_byte;
      end else if (byte_count < 8'd6) begin
        if ((byte_count - 8'd2) < clamp8) begin
          accum_next[8*(byte_count[1:0] - 2'd2) +: 8] = in_data.frame_byte;
        end
      end
      if (byte_count != 8'hFF) byte_count_next = byte_count + 8'd1;
    end
  end

  assign clamp8 = (declared_len > 8'(MaxParamLen)) ? 8'(MaxParamLen) : declared_len;
  assign clamped = (declared_next > 8'(MaxParamLen));
  assign len = clamped ? LenW'(MaxParamLen) : declared_next[LenW-1:0];

  cfpv_check u_check (
    .cfg  (cfg),
    .code (code_next),
    .len  (len),
    .word (accum_next),
    .ok   (ok)
  );

  always_comb begin
    result.command_code = code_next;
    result.param_length = len;
    result.length_clamped = clamped;
    result.param_word = accum_next;
    if (byte_count_next < 8'd2) begin
      result = '0;
      result.status = StatusShort;
    end else if ({1'b0, byte_count_next} < ({1'b0, 2'b0, len} + 9'd2)) begin
      result.status = StatusTrunc;
    end else if (!ok) begin
      result.status = StatusInvalid;
    end else begin
      result.status = StatusOk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      code_reg <= '0;
      declared_len <= '0;
      param_accum <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (take) begin
        if (in_data.frame_end) begin
          byte_count <= '0;
          code_reg <= '0;
          declared_len <= '0;
          param_accum <= '0;
          out_valid <= 1'b1;
        end else begin
          byte_count <= byte_count_next;
          code_reg <= code_next;
          declared_len <= declared_next;
          param_accum <= accum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_data.frame_end) out_data <= result;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result lost under stall");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    take && in_data.frame_end |=> byte_count == 8'd0 && param_accum == 32'd0)
    else $error("frame state not cleared");
  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.param_length <= LenW'(MaxParamLen))
    else $error("length above clamp");
  a_short: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == StatusShort |-> out_data.param_word == 32'd0)
    else $error("short frame with data");

endmodule
`default_nettype wire
